// ----- hw/rtl/pds_pkg.sv -----
// Package with the word types, character constants and hex helpers of the percent decoder.
package pds_pkg;

    localparam logic [7:0] PctChar  = 8'h25;
    localparam logic [7:0] UpperA   = 8'h41;
    localparam logic [7:0] UpperF   = 8'h46;
    localparam logic [7:0] Digit0   = 8'h30;
    localparam logic [7:0] Digit9   = 8'h39;
    localparam logic [7:0] AlphaOff = 8'd10;
    localparam int         MaxRes   = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef struct packed {
        logic [1:0]          cnt;
        t_out [MaxRes-1:0]   items;
    } t_res;

    function automatic logic is_hex(input logic [7:0] c);
        is_hex = ((c >= UpperA) && (c <= UpperF)) || ((c >= Digit0) && (c <= Digit9));
    endfunction

    function automatic logic [3:0] hex_nib(input logic [7:0] c);
        logic [7:0] v;
        if ((c >= UpperA) && (c <= UpperF)) begin
            v = c - UpperA + AlphaOff;
        end else begin
            v = c - Digit0;
        end
        hex_nib = v[3:0];
    endfunction

endpackage

// ----- hw/rtl/pds_decode.sv -----
// Escape state and the combinational decode of one word into up to three result words.
module pds_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pds_pkg::t_in   i_data,
    input  logic           i_take,
    output pds_pkg::t_res  o_res
);

    logic [1:0] r_pcount;
    logic [1:0] n_pcount;
    logic [7:0] r_digit;
    logic [7:0] n_digit;

    always_comb begin
        logic [1:0] idx;
        logic       fresh;
        logic [7:0] b;
        logic       last;
        idx      = 2'd0;
        fresh    = 1'b0;
        b        = i_data.in_byte;
        last     = i_data.in_last;
        o_res    = '0;
        n_pcount = 2'd0;
        n_digit  = r_digit;
        case (r_pcount)
            2'd1: begin
                if (pds_pkg::is_hex(b) && !last) begin
                    n_pcount = 2'd2;
                    n_digit  = b;
                end else begin
                    o_res.items[idx] = '{out_byte: pds_pkg::PctChar, out_last: 1'b0};
                    idx   = idx + 2'd1;
                    fresh = 1'b1;
                end
            end
            2'd2: begin
                if (pds_pkg::is_hex(b) && pds_pkg::is_hex(r_digit)) begin
                    o_res.items[idx] = '{out_byte: {pds_pkg::hex_nib(r_digit),
                                                    pds_pkg::hex_nib(b)},
                                         out_last: last};
                    idx = idx + 2'd1;
                end else begin
                    o_res.items[idx] = '{out_byte: pds_pkg::PctChar, out_last: 1'b0};
                    idx = idx + 2'd1;
                    o_res.items[idx] = '{out_byte: r_digit, out_last: 1'b0};
                    idx   = idx + 2'd1;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        if (fresh) begin
            if ((b == pds_pkg::PctChar) && !last) begin
                n_pcount = 2'd1;
            end else begin
                o_res.items[idx] = '{out_byte: b, out_last: last};
                idx = idx + 2'd1;
            end
        end
        o_res.cnt = idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount <= 2'd0;
            r_digit  <= 8'd0;
        end else if (i_take) begin
            r_pcount <= n_pcount;
            r_digit  <= n_digit;
        end
    end

`ifndef SYNTHESIS
    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount != 2'd3)
        else $error("Pending count reached an unused code.");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_data.in_last) |=> (r_pcount == 2'd0))
        else $error("Escape state survived the end of a string.");

    a_digit_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pcount == 2'd2) |-> pds_pkg::is_hex(r_digit))
        else $error("Held escape digit is not a hex digit.");
`endif

endmodule

// ----- hw/rtl/pds_emit.sv -----
// Result register of up to three decoded words, handed out one per cycle when i_ready.
module pds_emit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pds_pkg::t_res  i_res,
    input  logic           i_load,
    output logic           o_free,
    output logic           o_valid,
    input  logic           i_ready,
    output pds_pkg::t_out  o_data
);

    logic [1:0]                        r_cnt;
    logic [1:0]                        n_cnt;
    pds_pkg::t_out [pds_pkg::MaxRes-1:0] r_items;
    pds_pkg::t_out [pds_pkg::MaxRes-1:0] n_items;
    logic                              pop;

    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_items[0];
    assign pop     = o_valid && i_ready;
    assign o_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_items = r_items;
        if (i_load) begin
            n_cnt   = i_res.cnt;
            n_items = i_res.items;
        end else if (pop) begin
            n_cnt      = r_cnt - 2'd1;
            n_items[0] = r_items[1];
            n_items[1] = r_items[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_items <= n_items;
    end

`ifndef SYNTHESIS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("Result register loaded while earlier words were still waiting.");
`endif

endmodule

// ----- hw/rtl/percent_decode_stream.sv -----
// Top level of the streaming percent decoder: input register, decode and result register.
// A word accepted into the input register is decoded and loaded into the result register,
// from which its first result is offered on the output.
// Throughput: one word per cycle while each word yields at most one result and the output
// is ready; after a word with more results the next waits until the last is handed out.
// Reset (synchronous, active low) empties both registers and clears any held escape.
module percent_decode_stream (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pds_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pds_pkg::t_out  o_out_data
);

    logic           r_valid;
    pds_pkg::t_in   r_in;
    pds_pkg::t_res  res;
    logic           free;
    logic           take;
    logic           load;

    assign take       = r_valid && ((res.cnt == 2'd0) || free);
    assign load       = take && (res.cnt != 2'd0);
    assign o_in_ready = !r_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    pds_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (r_in),
        .i_take  (take),
        .o_res   (res)
    );

    pds_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .i_load  (load),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule
